// ===== rtl/bea_pkg.sv =====
// Shared types and constants for the buffer entry allocator.
`timescale 1ns / 1ps
package bea_pkg;

   localparam int ENTRIES_DEFAULT    = 64;
   localparam int COUNT_BITS_DEFAULT = 8;

   localparam int KIND_W = 3;
   localparam int IDX_W  = 6;
   localparam int PRIO_W = 2;
   localparam int THR_W  = 6;
   localparam logic [THR_W-1:0] THR_RESET = 6'd16;

   // Request kinds.
   localparam logic [KIND_W-1:0] K_RESERVE = 3'd0;
   localparam logic [KIND_W-1:0] K_TOUCH   = 3'd1;
   localparam logic [KIND_W-1:0] K_USE     = 3'd2;
   localparam logic [KIND_W-1:0] K_RELEASE = 3'd3;
   localparam logic [KIND_W-1:0] K_SETPRIO = 3'd4;

   // Entry states.
   localparam logic [1:0] ES_FREE     = 2'd0;
   localparam logic [1:0] ES_RESERVED = 2'd1;
   localparam logic [1:0] ES_USING    = 2'd2;
   localparam logic [1:0] ES_IDLE     = 2'd3;

   // Entry priorities.
   localparam logic [1:0] PR_NORMAL = 2'd0;
   localparam logic [1:0] PR_DROP   = 2'd1;
   localparam logic [1:0] PR_KEEP   = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_RMW_RD,
      S_RMW_WR,
      S_POP_RD,
      S_POP_WR,
      S_DF_RD,
      S_DF_WR,
      S_SW_RD,
      S_SW_WR,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic clear_wr;
      logic req_load;
      logic rmw_rd;
      logic rmw_wr;
      logic pop_rd;
      logic pop_wr;
      logic fail;
      logic noop_ok;
      logic df_init;
      logic df_rd;
      logic df_wr;
      logic pass_init;
      logic sw_rd;
      logic sw_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic kind_reserve;
      logic kind_simple;
      logic free_zero;
      logic head_zero;
      logic df_last;
      logic df_hit;
      logic released;
      logic sw_drop;
      logic sw_stop;
      logic last_visit;
      logic pinned_low;
      logic rsp_free;
   } sts_type;

endpackage

// ===== rtl/bea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bea_ctrl.sv =====
// Sequencer for reserve, release scans, clock sweep and simple updates.
`timescale 1ns / 1ps
module bea_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  bea_pkg::sts_type sts,
   output bea_pkg::cmd_type cmd
);

   bea_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bea_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         bea_pkg::S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = bea_pkg::S_IDLE;
         end
         bea_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in     = bea_pkg::S_DISPATCH;
            end
         end
         bea_pkg::S_DISPATCH: begin
            if (sts.kind_reserve) begin
               if (sts.free_zero) begin
                  cmd.df_init = 1'b1;
                  state_in    = bea_pkg::S_DF_RD;
               end else begin
                  state_in = bea_pkg::S_POP_RD;
               end
            end else if (sts.kind_simple) begin
               state_in = bea_pkg::S_RMW_RD;
            end else begin
               cmd.noop_ok = 1'b1;
               state_in    = bea_pkg::S_DONE;
            end
         end
         bea_pkg::S_RMW_RD: begin
            cmd.rmw_rd = 1'b1;
            state_in   = bea_pkg::S_RMW_WR;
         end
         bea_pkg::S_RMW_WR: begin
            cmd.rmw_wr = 1'b1;
            state_in   = bea_pkg::S_DONE;
         end
         bea_pkg::S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            if (sts.head_zero) begin
               cmd.fail = 1'b1;
               state_in = bea_pkg::S_DONE;
            end else begin
               state_in = bea_pkg::S_POP_WR;
            end
         end
         bea_pkg::S_POP_WR: begin
            cmd.pop_wr = 1'b1;
            state_in   = bea_pkg::S_DONE;
         end
         bea_pkg::S_DF_RD: begin
            cmd.df_rd = 1'b1;
            state_in  = bea_pkg::S_DF_WR;
         end
         bea_pkg::S_DF_WR: begin
            cmd.df_wr = 1'b1;
            if (!sts.df_last) begin
               state_in = bea_pkg::S_DF_RD;
            end else if (sts.released || sts.df_hit) begin
               state_in = bea_pkg::S_POP_RD;
            end else begin
               cmd.pass_init = 1'b1;
               state_in      = bea_pkg::S_SW_RD;
            end
         end
         bea_pkg::S_SW_RD: begin
            cmd.sw_rd = 1'b1;
            state_in  = bea_pkg::S_SW_WR;
         end
         bea_pkg::S_SW_WR: begin
            cmd.sw_wr = 1'b1;
            if (sts.sw_stop) begin
               state_in = bea_pkg::S_POP_RD;
            end else if (!sts.last_visit) begin
               state_in = bea_pkg::S_SW_RD;
            end else if (!sts.released && !sts.sw_drop && sts.pinned_low) begin
               cmd.pass_init = 1'b1;
               state_in      = bea_pkg::S_SW_RD;
            end else begin
               state_in = bea_pkg::S_POP_RD;
            end
         end
         bea_pkg::S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = bea_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bea_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bea_dp.sv =====
// Entry table, free list head, counters, clock hand and result registers.
`timescale 1ns / 1ps
module bea_dp #(
   parameter int ENTRIES    = bea_pkg::ENTRIES_DEFAULT,
   parameter int COUNT_BITS = bea_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bea_pkg::cmd_type              cmd,
   output bea_pkg::sts_type              sts,
   input  logic [bea_pkg::KIND_W-1:0]    req_kind,
   input  logic [bea_pkg::IDX_W-1:0]     req_idx,
   input  logic [bea_pkg::PRIO_W-1:0]    req_prio,
   input  logic                          csr_valid,
   input  logic [bea_pkg::THR_W-1:0]     csr_data,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic                          rsp_ok,
   output logic [bea_pkg::IDX_W-1:0]     rsp_granted,
   output logic [bea_pkg::IDX_W-1:0]     rsp_free
);

   localparam int IDXW = $clog2(ENTRIES);
   localparam int WW   = IDXW + COUNT_BITS + 4;
   localparam int EXW  = IDXW + bea_pkg::IDX_W;
   localparam int CMPW = IDXW + bea_pkg::THR_W;
   localparam int PW   = IDXW + 1;
   localparam logic [IDXW-1:0]       LAST    = IDXW'(ENTRIES - 1);
   localparam logic [IDXW-1:0]       ONE     = IDXW'(1);
   localparam logic [PW-1:0]         PIN_LIM = PW'(ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // Request registers.
   logic [bea_pkg::KIND_W-1:0] kind_ff;
   logic [bea_pkg::IDX_W-1:0]  idx_ff;
   logic [bea_pkg::PRIO_W-1:0] prio_ff;

   // Control and bookkeeping.
   logic [IDXW-1:0]           head_ff, head_in;
   logic [IDXW-1:0]           free_ff, free_in;
   logic [IDXW-1:0]           hand_ff, hand_in;
   logic [IDXW-1:0]           scan_ff, scan_in;
   logic [IDXW-1:0]           visit_ff, visit_in;
   logic [PW-1:0]             pinned_ff, pinned_in;
   logic                      released_ff, released_in;
   logic [bea_pkg::THR_W-1:0] thr_ff;
   logic                      ok_ff, ok_in;
   logic [IDXW-1:0]           grant_ff, grant_in;
   logic                      rvalid_ff, rvalid_in;
   logic                      rok_ff;
   logic [bea_pkg::IDX_W-1:0] rgrant_ff, rfree_ff;

   // Memory port.
   logic            we;
   logic [IDXW-1:0] waddr, raddr;
   logic [WW-1:0]   wdata, rdata;

   // Read fields.
   logic [IDXW-1:0]       rd_link;
   logic [COUNT_BITS-1:0] rd_cnt, dec_cnt;
   logic [1:0]            rd_pr, rd_st, new_pr;
   logic [EXW-1:0]        idx_ext;
   logic [IDXW-1:0]       idx_addr;
   logic                  sw_skip, sw_freeable, sw_drop, df_hit;
   logic [PW-1:0]         pinned_next;
   logic [IDXW-1:0]       free_plus;
   logic [EXW-1:0]        grant_ext, free_ext;

   bea_ram #(
      .WIDTH (WW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rd_link  = rdata[IDXW-1:0];
   assign rd_cnt   = rdata[IDXW +: COUNT_BITS];
   assign rd_pr    = rdata[IDXW+COUNT_BITS +: 2];
   assign rd_st    = rdata[IDXW+COUNT_BITS+2 +: 2];
   assign dec_cnt  = (rd_cnt != '0) ? rd_cnt - COUNT_BITS'(1) : rd_cnt;
   assign idx_ext  = {{IDXW{1'b0}}, idx_ff};
   assign idx_addr = idx_ext[IDXW-1:0];
   assign new_pr   = (prio_ff > bea_pkg::PR_KEEP) ? bea_pkg::PR_KEEP : prio_ff;
   assign free_plus = free_ff + ONE;

   assign df_hit      = (rd_st == bea_pkg::ES_IDLE) && (rd_pr == bea_pkg::PR_DROP);
   assign sw_skip     = (rd_st == bea_pkg::ES_FREE) || (rd_st == bea_pkg::ES_RESERVED);
   assign sw_freeable = (rd_pr == bea_pkg::PR_NORMAL) && (rd_st == bea_pkg::ES_IDLE);
   assign sw_drop     = !sw_skip && sw_freeable && (dec_cnt == '0);
   assign pinned_next = pinned_ff + PW'(sw_skip || !sw_freeable);

   // Read address.
   always_comb begin
      raddr = hand_ff;
      if (cmd.rmw_rd) raddr = idx_addr;
      else if (cmd.pop_rd) raddr = head_ff;
      else if (cmd.df_rd) raddr = scan_ff;
   end

   // Write port: clear, update, pop and drop words.
   always_comb begin
      we    = 1'b0;
      waddr = hand_ff;
      wdata = {rd_st, rd_pr, dec_cnt, rd_link};
      if (cmd.clear_wr) begin
         we    = 1'b1;
         waddr = scan_ff;
         wdata = {bea_pkg::ES_FREE, bea_pkg::PR_NORMAL, {COUNT_BITS{1'b0}},
                  (scan_ff == LAST) ? {IDXW{1'b0}} : scan_ff + ONE};
      end else if (cmd.rmw_wr) begin
         we    = 1'b1;
         waddr = idx_addr;
         wdata = rdata;
         case (kind_ff)
            bea_pkg::K_TOUCH: begin
               if (rd_cnt != CNT_MAX) wdata = {rd_st, rd_pr, rd_cnt + COUNT_BITS'(1), rd_link};
            end
            bea_pkg::K_USE: begin
               if (rd_st != bea_pkg::ES_FREE) wdata = {bea_pkg::ES_USING, rd_pr, rd_cnt, rd_link};
            end
            bea_pkg::K_RELEASE: begin
               if (rd_st != bea_pkg::ES_FREE) wdata = {bea_pkg::ES_IDLE, rd_pr, rd_cnt, rd_link};
            end
            bea_pkg::K_SETPRIO: begin
               wdata = {rd_st, new_pr, rd_cnt, rd_link};
            end
            default: begin
               wdata = rdata;
            end
         endcase
      end else if (cmd.pop_wr) begin
         we    = 1'b1;
         waddr = head_ff;
         wdata = {bea_pkg::ES_RESERVED, bea_pkg::PR_NORMAL, {COUNT_BITS{1'b0}}, head_ff};
      end else if (cmd.df_wr) begin
         we    = df_hit;
         waddr = scan_ff;
         wdata = {bea_pkg::ES_FREE, rd_pr, {COUNT_BITS{1'b0}}, head_ff};
      end else if (cmd.sw_wr) begin
         we    = !sw_skip;
         waddr = hand_ff;
         if (sw_drop) wdata = {bea_pkg::ES_FREE, rd_pr, {COUNT_BITS{1'b0}}, head_ff};
      end
   end

   // Bookkeeping next state.
   always_comb begin
      head_in     = head_ff;
      free_in     = free_ff;
      hand_in     = hand_ff;
      scan_in     = scan_ff;
      visit_in    = visit_ff;
      pinned_in   = pinned_ff;
      released_in = released_ff;
      ok_in       = ok_ff;
      grant_in    = grant_ff;
      if (cmd.clear_wr) scan_in = scan_ff + ONE;
      if (cmd.df_init) begin
         scan_in     = ONE;
         released_in = 1'b0;
      end
      if (cmd.df_wr) begin
         scan_in = scan_ff + ONE;
         if (df_hit) begin
            head_in     = scan_ff;
            free_in     = free_plus;
            released_in = 1'b1;
         end
      end
      if (cmd.sw_wr) begin
         visit_in  = visit_ff + ONE;
         pinned_in = pinned_next;
         if (sw_drop) begin
            head_in     = hand_ff;
            free_in     = free_plus;
            released_in = 1'b1;
         end
         if (!sts.sw_stop) hand_in = (hand_ff == LAST) ? ONE : hand_ff + ONE;
      end
      if (cmd.pass_init) begin
         visit_in  = '0;
         pinned_in = '0;
      end
      if (cmd.pop_wr) begin
         head_in  = rd_link;
         if (free_ff != '0) free_in = free_ff - ONE;
         ok_in    = 1'b1;
         grant_in = head_ff;
      end
      if (cmd.fail) begin
         ok_in    = 1'b0;
         grant_in = '0;
      end
      if (cmd.noop_ok || cmd.rmw_wr) begin
         ok_in    = 1'b1;
         grant_in = '0;
      end
   end

   assign grant_ext = {{bea_pkg::IDX_W{1'b0}}, grant_ff};
   assign free_ext  = {{bea_pkg::IDX_W{1'b0}}, free_ff};
   assign rvalid_in = cmd.rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= ONE;
         free_ff     <= LAST;
         hand_ff     <= ONE;
         scan_ff     <= '0;
         released_ff <= 1'b0;
         thr_ff      <= bea_pkg::THR_RESET;
         rvalid_ff   <= 1'b0;
      end else begin
         head_ff     <= head_in;
         free_ff     <= free_in;
         hand_ff     <= hand_in;
         scan_ff     <= scan_in;
         released_ff <= released_in;
         rvalid_ff   <= rvalid_in;
         if (csr_valid) thr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      visit_ff  <= visit_in;
      pinned_ff <= pinned_in;
      ok_ff     <= ok_in;
      grant_ff  <= grant_in;
      if (cmd.req_load) begin
         kind_ff <= req_kind;
         idx_ff  <= req_idx;
         prio_ff <= req_prio;
      end
      if (cmd.rsp_load) begin
         rok_ff    <= ok_ff;
         rgrant_ff <= grant_ext[bea_pkg::IDX_W-1:0];
         rfree_ff  <= free_ext[bea_pkg::IDX_W-1:0];
      end
   end

   always_comb begin
      sts              = '0;
      sts.clear_last   = (scan_ff == LAST);
      sts.kind_reserve = (kind_ff == bea_pkg::K_RESERVE);
      sts.kind_simple  = (kind_ff inside {bea_pkg::K_TOUCH, bea_pkg::K_USE,
                                          bea_pkg::K_RELEASE, bea_pkg::K_SETPRIO}) &&
                         (idx_ff != '0) && (idx_ext < EXW'(ENTRIES));
      sts.free_zero    = (free_ff == '0);
      sts.head_zero    = (head_ff == '0);
      sts.df_last      = (scan_ff == LAST);
      sts.df_hit       = df_hit;
      sts.released     = released_ff;
      sts.sw_drop      = sw_drop;
      sts.sw_stop      = sw_drop && (CMPW'(free_plus) > CMPW'(thr_ff));
      sts.last_visit   = (visit_ff == LAST);
      sts.pinned_low   = (pinned_next < PIN_LIM);
      sts.rsp_free     = !rvalid_ff || rsp_tready;
   end

   assign rsp_tvalid  = rvalid_ff;
   assign rsp_ok      = rok_ff;
   assign rsp_granted = rgrant_ff;
   assign rsp_free    = rfree_ff;

endmodule

// ===== rtl/buffer_entry_allocator_with_aging.sv =====
// Top level of the buffer entry allocator with clock-hand aging.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  req     | in        | req_tvalid/tready    | tuser: kind; tdata: entry_index, prio
//  rsp     | out       | rsp_tvalid/tready    | tdata: ok, granted_index, free_entries
//  csr     | in        | csr_valid/csr_ready  | csr_data: release_threshold
//
// One word is worked on at a time. Touch, use, release and set priority on a
// valid index, and a reserve finding a free entry, go through accept, dispatch,
// table read, table write and result load; other kinds and bad indices skip
// the table steps. A reserve on an empty list runs the drop-first scan and, if
// it frees nothing, the clock sweep; each scan step or visit is a table read
// and a table write. After reset every entry is cleared in turn; req_tready
// stays low meanwhile. A result waiting on rsp_tready stalls only the final step.
`timescale 1ns / 1ps
module buffer_entry_allocator_with_aging #(
   parameter int ENTRIES    = bea_pkg::ENTRIES_DEFAULT,
   parameter int COUNT_BITS = bea_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] entry_index, [7:6] new_priority
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] ok, [6:1] granted_index, [12:7] free_entries
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data     // release_threshold
);

   bea_pkg::cmd_type cmd;
   bea_pkg::sts_type sts;

   logic                          rsp_ok;
   logic [bea_pkg::IDX_W-1:0]     rsp_granted, rsp_free;

   // Threshold writes are always taken.
   assign csr_ready = 1'b1;

   bea_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bea_dp #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_kind    (req_tuser),
      .req_idx     (req_tdata[5:0]),
      .req_prio    (req_tdata[7:6]),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_ok      (rsp_ok),
      .rsp_granted (rsp_granted),
      .rsp_free    (rsp_free)
   );

   assign rsp_tdata = {3'b000, rsp_free, rsp_granted, rsp_ok};

endmodule

// ===== test/buffer_entry_allocator_with_aging_chk.sv =====
// Checker for the buffer entry allocator: tracks allocator state and compares responses.
`timescale 1ns / 1ps
module buffer_entry_allocator_with_aging_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [5:0]  csr_data,
   output int          errors,
   output int          pending,
   output int          checked,
   output int          failed_reserves
);

   localparam int N         = bea_pkg::ENTRIES_DEFAULT;
   localparam int COUNT_TOP = (1 << bea_pkg::COUNT_BITS_DEFAULT) - 1;

   typedef struct packed {
      logic       ok;
      logic [5:0] grant;
      logic [5:0] free_n;
   } alloc_rsp_type;

   logic [1:0]    ent_state [N];
   logic [1:0]    ent_prio  [N];
   int            ent_count [N];
   int            ent_next  [N];
   int            free_total;
   int            hand;
   int            threshold;
   alloc_rsp_type rsp_q [$];

   function automatic void table_reset();
      for (int i = 0; i < N; i++) begin
         ent_state[i] = bea_pkg::ES_FREE;
         ent_prio[i]  = bea_pkg::PR_NORMAL;
         ent_count[i] = 0;
         ent_next[i]  = (i + 1 < N) ? i + 1 : 0;
      end
      free_total = N - 1;
      hand       = 1;
      threshold  = bea_pkg::THR_RESET;
   endfunction

   function automatic void free_entry(int i);
      if (ent_state[i] != bea_pkg::ES_FREE) begin
         ent_next[i]  = ent_next[0];
         ent_next[0]  = i;
         ent_state[i] = bea_pkg::ES_FREE;
         ent_count[i] = 0;
         free_total++;
      end
   endfunction

   // Drop-first scan, then clock sweep if nothing was dropped; true if anything was freed.
   function automatic bit reclaim();
      int  dropped;
      int  pinned;
      int  h;
      bit  stop;
      dropped = 0;
      for (int i = 1; i < N; i++)
         if (ent_state[i] == bea_pkg::ES_IDLE && ent_prio[i] == bea_pkg::PR_DROP) begin
            free_entry(i);
            dropped++;
         end
      if (dropped > 0) return 1'b1;
      do begin
         pinned = 0;
         stop   = 1'b0;
         for (int v = 0; v < N && !stop; v++) begin
            pinned++;
            if (hand == 0 || hand >= N) hand = 1;
            h = hand;
            if (ent_state[h] == bea_pkg::ES_FREE || ent_state[h] == bea_pkg::ES_RESERVED) begin
               hand = hand % (N - 1) + 1;
            end else begin
               if (ent_count[h] > 0) ent_count[h]--;
               if (ent_prio[h] == bea_pkg::PR_NORMAL && ent_state[h] == bea_pkg::ES_IDLE) begin
                  pinned--;
                  if (ent_count[h] == 0) begin
                     free_entry(h);
                     dropped++;
                     if (free_total > threshold) stop = 1'b1;
                  end
               end
               if (!stop) hand = hand % (N - 1) + 1;
            end
         end
      end while (dropped == 0 && pinned < N - 1);
      return dropped > 0;
   endfunction

   function automatic alloc_rsp_type apply_request(int kind, int idx, int prio);
      alloc_rsp_type r;
      bit            have;
      int            e;
      r.ok    = 1'b1;
      r.grant = '0;
      if (kind == bea_pkg::K_RESERVE) begin
         have = 1'b1;
         if (free_total == 0) have = reclaim();
         if (have && ent_next[0] != 0) begin
            e            = ent_next[0];
            ent_next[0]  = ent_next[e];
            ent_next[e]  = e;
            ent_state[e] = bea_pkg::ES_RESERVED;
            ent_prio[e]  = bea_pkg::PR_NORMAL;
            ent_count[e] = 0;
            if (free_total > 0) free_total--;
            r.grant = e[5:0];
         end else begin
            r.ok = 1'b0;
         end
      end else if (idx != 0 && idx < N) begin
         case (kind)
            bea_pkg::K_TOUCH:
               if (ent_count[idx] < COUNT_TOP) ent_count[idx]++;
            bea_pkg::K_USE:
               if (ent_state[idx] != bea_pkg::ES_FREE) ent_state[idx] = bea_pkg::ES_USING;
            bea_pkg::K_RELEASE:
               if (ent_state[idx] != bea_pkg::ES_FREE) ent_state[idx] = bea_pkg::ES_IDLE;
            bea_pkg::K_SETPRIO:
               ent_prio[idx] = (prio > bea_pkg::PR_KEEP) ? bea_pkg::PR_KEEP : prio[1:0];
            default: ;
         endcase
      end
      r.free_n = free_total[5:0];
      return r;
   endfunction

   assign pending = rsp_q.size();

   always @(posedge clock) begin
      alloc_rsp_type want;
      alloc_rsp_type got;
      if (reset) begin
         table_reset();
         rsp_q.delete();
         errors          <= 0;
         checked         <= 0;
         failed_reserves <= 0;
      end else begin
         if (csr_valid && csr_ready) threshold = csr_data;
         if (req_tvalid && req_tready)
            rsp_q.push_back(apply_request(req_tuser, req_tdata[5:0], req_tdata[7:6]));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[6:1], rsp_tdata[12:7]};
            checked <= checked + 1;
            if (!got.ok) failed_reserves <= failed_reserves + 1;
            if (rsp_q.size() == 0) begin
               if (errors < 10) $display("ERROR: unexpected response word %h", rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = rsp_q.pop_front();
               if (want != got) begin
                  if (errors < 10)
                     $display({"ERROR: resp %0d exp ok=%0d idx=%0d free=%0d ",
                               "got ok=%0d idx=%0d free=%0d"},
                              checked, want.ok, want.grant, want.free_n,
                              got.ok, got.grant, got.free_n);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

// ===== test/buffer_entry_allocator_with_aging_tb.sv =====
// Testbench top for the buffer entry allocator: stimulus, clocking and verdict.
`timescale 1ns / 1ps
module buffer_entry_allocator_with_aging_tb;

   localparam int RAND_WORDS = 1300;
   localparam int HOLD_AT    = 300;   // response count that triggers the long stall
   localparam int HOLD_LEN   = 600;

   // Kind codes with no operation behind them.
   localparam logic [2:0] K_SPARE_LO  = 3'd5;
   localparam logic [2:0] K_SPARE_MID = 3'd6;
   localparam logic [2:0] K_SPARE_HI  = 3'd7;
   // Out-of-range priority code, stored as keep.
   localparam logic [1:0] PR_ODD = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   int errors, pending, checked, failed_reserves;
   int words_sent = 0;
   bit send_burst = 1'b0;   // no gaps on the request side while set

   buffer_entry_allocator_with_aging u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   buffer_entry_allocator_with_aging_chk u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .errors          (errors),
      .pending         (pending),
      .checked         (checked),
      .failed_reserves (failed_reserves)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Generous cap: a sweep on a full table may run long.
   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   // Sends one request word; returns right after the accepting edge.
   task automatic send_word(input logic [2:0] kind, input logic [5:0] idx,
                            input logic [1:0] prio);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {prio, idx};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      words_sent++;
   endtask

   // Lowers valid, then waits until everything in flight has drained.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Threshold write; block is idle when this is called.
   task automatic write_threshold(input logic [5:0] thr);
      csr_valid <= 1'b1;
      csr_data  <= thr;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random request mix, skewed so the free list empties and reclaim runs often.
   task automatic send_random();
      int          pick;
      logic [2:0]  kind;
      logic [5:0]  idx;
      pick = $urandom_range(0, 99);
      if      (pick < 34) kind = bea_pkg::K_RESERVE;
      else if (pick < 44) kind = bea_pkg::K_TOUCH;
      else if (pick < 60) kind = bea_pkg::K_USE;
      else if (pick < 84) kind = bea_pkg::K_RELEASE;
      else if (pick < 96) kind = bea_pkg::K_SETPRIO;
      else                kind = 3'($urandom_range(K_SPARE_LO, K_SPARE_HI));
      idx = ($urandom_range(0, 31) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
      send_word(kind, idx, 2'($urandom));
   endtask

   // Response side: random stalls, burst stretches, one long hold-off.
   initial begin
      int  gap;
      int  seen;
      bit  burst;
      bit  held;
      seen = 0;
      burst = 1'b0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (seen % 80 == 0) burst = ($urandom_range(0, 3) == 0);
         gap = burst ? 0 : $urandom_range(0, 15);
         if (!held && seen >= HOLD_AT) begin
            gap  = HOLD_LEN;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         while (!rsp_tvalid) @(negedge clock);
         @(posedge clock);
         seen++;
      end
   end

   initial begin
      logic [5:0] thr_plan [4];
      thr_plan[0] = 6'd0;
      thr_plan[1] = 6'd63;
      thr_plan[2] = 6'($urandom_range(1, 62));
      thr_plan[3] = 6'd5;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every kind, edge indices, odd priority code, unused kinds.
      send_word(bea_pkg::K_TOUCH,   6'd63, bea_pkg::PR_NORMAL);   // touch of a free entry
      send_word(bea_pkg::K_USE,     6'd63, bea_pkg::PR_NORMAL);   // use of a free entry
      send_word(bea_pkg::K_RELEASE, 6'd62, bea_pkg::PR_NORMAL);   // release of a free entry
      send_word(bea_pkg::K_RESERVE, 6'd0,  PR_ODD);
      send_word(bea_pkg::K_RESERVE, 6'd63, bea_pkg::PR_NORMAL);
      send_word(bea_pkg::K_USE,     6'd1,  bea_pkg::PR_NORMAL);
      send_word(bea_pkg::K_TOUCH,   6'd1,  bea_pkg::PR_NORMAL);
      send_word(bea_pkg::K_RELEASE, 6'd1,  bea_pkg::PR_NORMAL);
      send_word(bea_pkg::K_SETPRIO, 6'd1,  PR_ODD);               // becomes keep
      send_word(bea_pkg::K_SETPRIO, 6'd2,  bea_pkg::PR_DROP);
      send_word(bea_pkg::K_SETPRIO, 6'd2,  bea_pkg::PR_NORMAL);
      send_word(bea_pkg::K_TOUCH,   6'd0,  bea_pkg::PR_KEEP);     // entry zero: still ok
      send_word(bea_pkg::K_USE,     6'd0,  bea_pkg::PR_NORMAL);
      send_word(bea_pkg::K_RELEASE, 6'd0,  bea_pkg::PR_NORMAL);
      send_word(bea_pkg::K_SETPRIO, 6'd0,  bea_pkg::PR_KEEP);
      send_word(K_SPARE_LO,         6'd1,  bea_pkg::PR_DROP);
      send_word(K_SPARE_MID,        6'd42, bea_pkg::PR_KEEP);
      send_word(K_SPARE_HI,         6'd63, PR_ODD);
      wait_drained();

      // Random phases, one threshold each; sender pauses for a full drain between.
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(thr_plan[ph]);
         for (int n = 0; n < RAND_WORDS / 4; n++) begin
            if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
            send_random();
         end
         send_burst = 1'b0;
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d request words over 4 threshold settings (0, 63, random, 5).",
               words_sent);
      $display("Checked %0d responses, %0d of them failed reserves.",
               checked, failed_reserves);
      if (errors == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bea_pkg.sv
rtl/bea_ram.sv
rtl/bea_ctrl.sv
rtl/bea_dp.sv
rtl/buffer_entry_allocator_with_aging.sv
test/buffer_entry_allocator_with_aging_chk.sv
test/buffer_entry_allocator_with_aging_tb.sv
